@@ rtl/gzp_pkg.sv @@
// Shared types, widths and codes for the ghost zone padding address generator.
`default_nettype none

package gzp_pkg;

  localparam int unsigned EXT_W   = 7;   // extent register width
  localparam int unsigned GH_W    = 4;   // ghost_zones register width
  localparam int unsigned CMD_W   = 3;
  localparam int unsigned WORD_W  = 64;
  localparam int unsigned ADDR_W  = 19;
  localparam int unsigned CNT_W   = EXT_W;      // region counters
  localparam int unsigned CRD_W   = EXT_W + 1;  // padded coordinate / padded size
  localparam int unsigned MID_W   = 2 * CRD_W + 1;
  localparam int unsigned FULL_W  = CRD_W + MID_W + 1;
  localparam int unsigned CFG_W   = EXT_W;
  localparam int unsigned IDX_W   = 2;

  localparam int unsigned DEF_MAX_EXTENT = 64;
  localparam int unsigned DEF_MAX_GHOST  = 8;

  localparam logic [CMD_W-1:0] CMD_INTERIOR = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INVALID  = 3'd7;

  typedef enum logic [IDX_W-1:0] {
    CFG_EXTENT_X    = 2'd0,
    CFG_EXTENT_Y    = 2'd1,
    CFG_EXTENT_Z    = 2'd2,
    CFG_GHOST_ZONES = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [EXT_W-1:0] extent_x;
    logic [EXT_W-1:0] extent_y;
    logic [EXT_W-1:0] extent_z;
    logic [GH_W-1:0]  ghost_zones;
  } cfg_t;

  // coordinates in the padded array plus the strides needed to linearize them
  typedef struct packed {
    logic [CRD_W-1:0]  pos_x;
    logic [CRD_W-1:0]  pos_y;
    logic [CRD_W-1:0]  pos_z;
    logic [CRD_W-1:0]  pad_x;
    logic [CRD_W-1:0]  pad_y;
    logic [WORD_W-1:0] word;
    logic              last;
  } walk_t;

endpackage

`default_nettype wire

@@ rtl/gzp_walk.sv @@
// Region decode and per-region counters; registers padded coordinates of each element.
`default_nettype none

module gzp_walk
  import gzp_pkg::*;
#(
  parameter int unsigned MAX_EXTENT = DEF_MAX_EXTENT,
  parameter int unsigned MAX_GHOST  = DEF_MAX_GHOST
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire cfg_t              cfg_i,
  input  wire logic              load_i,    // beat accepted this cycle
  input  wire logic              adv_i,     // stage register may advance
  input  wire logic [CMD_W-1:0]  cmd_i,
  input  wire logic              first_i,
  input  wire logic [WORD_W-1:0] word_i,
  output logic                   vld_o,
  output walk_t                  stg_o
);

  function automatic logic [EXT_W-1:0] clamp_ext(input logic [EXT_W-1:0] e);
    logic [EXT_W-1:0] r;
    r = e;
    if (e == '0) r = EXT_W'(1);
    else if (32'(e) > MAX_EXTENT) r = EXT_W'(MAX_EXTENT);
    return r;
  endfunction

  logic [EXT_W-1:0] ext    [3];
  logic [EXT_W-1:0] span   [3];
  logic [CRD_W-1:0] off    [3];
  logic [CRD_W-1:0] pad    [3];
  logic [CNT_W-1:0] cnt_d  [3];
  logic [CNT_W-1:0] cnt_q  [3];
  logic [CNT_W-1:0] use_c  [3];
  logic [CRD_W-1:0] inc    [3];
  logic [CMD_W-1:0] cur_d, cur_q;
  logic [GH_W-1:0]  gz;
  logic [1:0]       axis;
  logic             upper, keep, restart, last;
  logic             wrap_x, wrap_y;
  logic             vld_d, vld_q;
  walk_t            stg_d, stg_q;

  always_comb begin
    gz = (32'(cfg_i.ghost_zones) > MAX_GHOST) ? GH_W'(MAX_GHOST) : cfg_i.ghost_zones;
    ext[0] = clamp_ext(cfg_i.extent_x);
    ext[1] = clamp_ext(cfg_i.extent_y);
    ext[2] = clamp_ext(cfg_i.extent_z);
    axis  = 2'((cmd_i - CMD_W'(1)) >> 1);
    upper = ~cmd_i[0];
    keep  = (cmd_i != CMD_INVALID) && ((cmd_i == CMD_INTERIOR) || (gz != '0));

    for (int i = 0; i < 3; i++) begin
      pad[i]  = CRD_W'(ext[i]) + CRD_W'({gz, 1'b0});
      span[i] = ext[i];
      off[i]  = CRD_W'(gz);
      if ((cmd_i != CMD_INTERIOR) && (32'(axis) == i)) begin
        span[i] = EXT_W'(gz);
        off[i]  = upper ? CRD_W'(ext[i]) + CRD_W'(gz) : '0;
      end
    end

    restart = first_i || (cmd_i != cur_q) || (cnt_q[0] >= span[0]) ||
              (cnt_q[1] >= span[1]) || (cnt_q[2] >= span[2]);

    for (int i = 0; i < 3; i++) begin
      use_c[i] = restart ? '0 : cnt_q[i];
      inc[i]   = CRD_W'(use_c[i]) + CRD_W'(1);
    end

    last = (inc[0] == CRD_W'(span[0])) && (inc[1] == CRD_W'(span[1])) &&
           (inc[2] == CRD_W'(span[2]));

    // x fastest; wrap back to the region start after the last element
    wrap_x = inc[0] >= CRD_W'(span[0]);
    wrap_y = inc[1] >= CRD_W'(span[1]);
    cnt_d[0] = wrap_x ? '0 : inc[0][CNT_W-1:0];
    cnt_d[1] = use_c[1];
    cnt_d[2] = use_c[2];
    if (wrap_x) begin
      cnt_d[1] = wrap_y ? '0 : inc[1][CNT_W-1:0];
      if (wrap_y) begin
        cnt_d[2] = (inc[2] >= CRD_W'(span[2])) ? '0 : inc[2][CNT_W-1:0];
      end
    end
    cur_d = cmd_i;

    stg_d.pos_x = CRD_W'(use_c[0]) + off[0];
    stg_d.pos_y = CRD_W'(use_c[1]) + off[1];
    stg_d.pos_z = CRD_W'(use_c[2]) + off[2];
    stg_d.pad_x = pad[0];
    stg_d.pad_y = pad[1];
    stg_d.word  = word_i;
    stg_d.last  = last;

    vld_d = vld_q;
    if (adv_i) vld_d = load_i && keep;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      cur_q <= CMD_INTERIOR;
      for (int i = 0; i < 3; i++) cnt_q[i] <= '0;
    end else begin
      vld_q <= vld_d;
      if (load_i && keep) begin
        cur_q <= cur_d;
        for (int i = 0; i < 3; i++) cnt_q[i] <= cnt_d[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && load_i) stg_q <= stg_d;
  end

  assign vld_o = vld_q;
  assign stg_o = stg_q;

endmodule

`default_nettype wire

@@ rtl/gzp_addr.sv @@
// Two-stage linearization of padded coordinates with the output register.
`default_nettype none

module gzp_addr
  import gzp_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               vld_i,
  input  wire walk_t              stg_i,
  output logic                    rdy_o,
  output logic                    out_vld_o,
  input  wire logic               out_rdy_i,
  output logic [ADDR_W-1:0]       addr_o,
  output logic [WORD_W-1:0]       word_o,
  output logic                    last_o
);

  logic              en_mid, en_out;
  logic              mid_vld_q, out_vld_q;
  logic [MID_W-1:0]  mid_d, mid_q;       // pad_y * pos_z + pos_y
  logic [CRD_W-1:0]  px_q, padx_q;
  logic [WORD_W-1:0] mword_q, word_q;
  logic              mlast_q, last_q;
  logic [FULL_W-1:0] full_d;
  logic [ADDR_W-1:0] addr_q;

  assign en_out = !out_vld_q || out_rdy_i;
  assign en_mid = !mid_vld_q || en_out;
  assign rdy_o  = en_mid;

  assign mid_d  = MID_W'(stg_i.pad_y) * MID_W'(stg_i.pos_z) + MID_W'(stg_i.pos_y);
  assign full_d = FULL_W'(padx_q) * FULL_W'(mid_q) + FULL_W'(px_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (en_mid) mid_vld_q <= vld_i;
      if (en_out) out_vld_q <= mid_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_mid && vld_i) begin
      mid_q   <= mid_d;
      px_q    <= stg_i.pos_x;
      padx_q  <= stg_i.pad_x;
      mword_q <= stg_i.word;
      mlast_q <= stg_i.last;
    end
    if (en_out && mid_vld_q) begin
      addr_q <= full_d[ADDR_W-1:0];
      word_q <= mword_q;
      last_q <= mlast_q;
    end
  end

  assign out_vld_o = out_vld_q;
  assign addr_o    = addr_q;
  assign word_o    = word_q;
  assign last_o    = last_q;

endmodule

`default_nettype wire

@@ rtl/ghost_zone_pad_address_gen.sv @@
// Top level: ghost zone padding scatter-address generator.
//
//  channel  | signals                        | content
//  ---------+--------------------------------+---------------------------------------
//  input    | s_axis_tvalid/tready/tdata/tuser | tdata: word_in; tuser: command, first
//  output   | m_axis_tvalid/tready/tdata/tlast | tdata: padded_address, word_out;
//           |                                |   tlast: region_done
//  config   | cfg_we_i, cfg_idx_i, cfg_data_i | extent_x/y/z, ghost_zones
//
// One beat per cycle sustained while the output is ready; the counter stage and the two
// multiplies of the address are each followed by a register.
// Reset clears counters, region and pipeline valids; registers return to 8/8/8/2.
// Each stage holds independently, so input beats keep flowing into empty stages
// while a result waits on the output. Invalid commands and zero-thickness faces
// are taken and dropped.
`default_nettype none

module ghost_zone_pad_address_gen
  import gzp_pkg::*;
#(
  parameter int unsigned MAX_EXTENT = DEF_MAX_EXTENT,
  parameter int unsigned MAX_GHOST  = DEF_MAX_GHOST
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0] cfg_data_i,
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  input  wire logic [63:0]      s_axis_tdata,   // [63:0] word_in
  input  wire logic [3:0]       s_axis_tuser,   // [2:0] command, [3] first
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  output logic [87:0]           m_axis_tdata,   // [18:0] padded_address, [82:19] word_out
  output logic                  m_axis_tlast    // region_done
);

  cfg_t              cfg_q;
  logic              load, adv, walk_vld, addr_rdy;
  walk_t             walk_stg;
  logic [ADDR_W-1:0] addr;
  logic [WORD_W-1:0] word;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.extent_x    <= EXT_W'(8);
      cfg_q.extent_y    <= EXT_W'(8);
      cfg_q.extent_z    <= EXT_W'(8);
      cfg_q.ghost_zones <= GH_W'(2);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_EXTENT_X:    cfg_q.extent_x    <= cfg_data_i[EXT_W-1:0];
        CFG_EXTENT_Y:    cfg_q.extent_y    <= cfg_data_i[EXT_W-1:0];
        CFG_EXTENT_Z:    cfg_q.extent_z    <= cfg_data_i[EXT_W-1:0];
        CFG_GHOST_ZONES: cfg_q.ghost_zones <= cfg_data_i[GH_W-1:0];
        default: ;
      endcase
    end
  end

  assign adv           = !walk_vld || addr_rdy;
  assign s_axis_tready = adv;
  assign load          = s_axis_tvalid && adv;

  gzp_walk #(
    .MAX_EXTENT (MAX_EXTENT),
    .MAX_GHOST  (MAX_GHOST)
  ) u_walk (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .load_i  (load),
    .adv_i   (adv),
    .cmd_i   (s_axis_tuser[CMD_W-1:0]),
    .first_i (s_axis_tuser[CMD_W]),
    .word_i  (s_axis_tdata),
    .vld_o   (walk_vld),
    .stg_o   (walk_stg)
  );

  gzp_addr u_addr (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .vld_i     (walk_vld),
    .stg_i     (walk_stg),
    .rdy_o     (addr_rdy),
    .out_vld_o (m_axis_tvalid),
    .out_rdy_i (m_axis_tready),
    .addr_o    (addr),
    .word_o    (word),
    .last_o    (m_axis_tlast)
  );

  assign m_axis_tdata = {5'b0, word, addr};

endmodule

`default_nettype wire
